// ----- rtl/dmis_pkg.sv -----
// ----------------------------------------------------------------------------
// dmis_pkg
// Shared types and constants for the distinct-value sorter.
// ----------------------------------------------------------------------------
package dmis_pkg;

    localparam int VALUE_W           = 31;
    localparam int TDATA_W           = 32;
    localparam int DEFAULT_MAX_ITEMS = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DUP_SCAN,
        ST_INSERT,
        ST_SEL_SCAN,
        ST_PUSH
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input transaction, start duplicate scan
        logic scan;      // advance the store walk by one entry
        logic insert;    // append value unless duplicate or full
        logic sel_init;  // begin the output run
        logic push;      // move the selected minimum into the output register
        logic finish;    // end of set: clear count and overflow
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic last;
        logic out_free;
        logic final_item;
    } sts_t;

endpackage

// ----- rtl/dedup_merge_insertion_sorter.sv -----
// ----------------------------------------------------------------------------
// dedup_merge_insertion_sorter
// Collects distinct values and streams them out in ascending order.
// ----------------------------------------------------------------------------
// Each input transaction carries one value; a value already held is dropped,
// and a new value arriving with the store full (MAX_ITEMS entries) is dropped
// and sets the overflow flag. Loading an item walks the store to check for
// duplicates, and s_tready is low meanwhile. The transaction with s_tlast
// ends the set: the block then emits the values held in ascending order,
// finding each one by a minimum search over the store. m_tlast marks the
// largest value and m_tuser carries the overflow flag on every result of
// the run. The next set may start loading while the final result still
// waits in the output register.
module dedup_merge_insertion_sorter #(
    parameter int MAX_ITEMS = dmis_pkg::DEFAULT_MAX_ITEMS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dmis_pkg::TDATA_W-1:0]  s_tdata,   // [30:0] value, [31] ignored
    input  logic                          s_tlast,   // last_in
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dmis_pkg::TDATA_W-1:0]  m_tdata,   // [30:0] sorted_value, [31] zero
    output logic                          m_tlast,   // last_out
    output logic                          m_tuser    // overflowed
);

    dmis_pkg::cmd_t               cmd;
    dmis_pkg::sts_t               sts;
    logic [dmis_pkg::VALUE_W-1:0] out_value;

    dmis_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dmis_dpath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_value  (s_tdata[dmis_pkg::VALUE_W-1:0]),
        .in_last   (s_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_value (out_value),
        .out_last  (m_tlast),
        .out_ovf   (m_tuser)
    );

    assign m_tdata = {{(dmis_pkg::TDATA_W - dmis_pkg::VALUE_W){1'b0}}, out_value};

    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> (!m_tvalid || m_tready))
        else $error("result pushed over an untaken result");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("new transaction taken while one is being loaded");

    a_final_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.push && sts.final_item) |=> (m_tvalid && m_tlast))
        else $error("final result of a run not marked last");

endmodule

// ----- rtl/dmis_ctrl.sv -----
// ----------------------------------------------------------------------------
// dmis_ctrl
// Sequencer: load, duplicate scan, insert, then one minimum search per result.
// ----------------------------------------------------------------------------
module dmis_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  dmis_pkg::sts_t sts,
    output dmis_pkg::cmd_t cmd
);

    dmis_pkg::state_t state_reg;
    dmis_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dmis_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dmis_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = dmis_pkg::ST_DUP_SCAN;
                end
            end
            dmis_pkg::ST_DUP_SCAN: begin
                if (sts.scan_done) begin
                    state_next = dmis_pkg::ST_INSERT;
                end
            end
            dmis_pkg::ST_INSERT: begin
                state_next = sts.last ? dmis_pkg::ST_SEL_SCAN : dmis_pkg::ST_IDLE;
            end
            dmis_pkg::ST_SEL_SCAN: begin
                if (sts.scan_done) begin
                    state_next = dmis_pkg::ST_PUSH;
                end
            end
            dmis_pkg::ST_PUSH: begin
                if (sts.out_free) begin
                    state_next = sts.final_item ? dmis_pkg::ST_IDLE : dmis_pkg::ST_SEL_SCAN;
                end
            end
            default: begin
                state_next = dmis_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            dmis_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            dmis_pkg::ST_DUP_SCAN: begin
                cmd.scan = 1'b1;
            end
            dmis_pkg::ST_INSERT: begin
                cmd.insert   = 1'b1;
                cmd.sel_init = sts.last;
            end
            dmis_pkg::ST_SEL_SCAN: begin
                cmd.scan = 1'b1;
            end
            dmis_pkg::ST_PUSH: begin
                cmd.push   = sts.out_free;
                cmd.finish = sts.out_free && sts.final_item;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/dmis_dpath.sv -----
// ----------------------------------------------------------------------------
// dmis_dpath
// Value store, walk counter, compare logic and output register.
// ----------------------------------------------------------------------------
module dmis_dpath #(
    parameter int MAX_ITEMS = dmis_pkg::DEFAULT_MAX_ITEMS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  dmis_pkg::cmd_t               cmd,
    output dmis_pkg::sts_t               sts,
    input  logic [dmis_pkg::VALUE_W-1:0] in_value,
    input  logic                         in_last,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [dmis_pkg::VALUE_W-1:0] out_value,
    output logic                         out_last,
    output logic                         out_ovf
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int VW = dmis_pkg::VALUE_W;

    logic [VW-1:0] mem [MAX_ITEMS];
    logic [VW-1:0] rd_data_reg;

    logic [VW-1:0] value_reg;
    logic          last_reg;
    logic [CW-1:0] count_reg;
    logic          ovf_reg;
    logic [CW-1:0] idx_reg;
    logic          pend_reg;
    logic          dup_reg;
    logic [VW-1:0] best_reg;
    logic          have_reg;
    logic [VW-1:0] prev_reg;
    logic          first_reg;
    logic [CW-1:0] emitted_reg;
    logic          out_valid_reg;
    logic [VW-1:0] out_value_reg;
    logic          out_last_reg;
    logic          out_ovf_reg;

    logic          more;
    logic          eligible;
    logic          full;
    logic          final_item;

    assign more       = idx_reg < count_reg;
    assign eligible   = first_reg || (rd_data_reg > prev_reg);
    assign full       = count_reg == CW'(MAX_ITEMS);
    assign final_item = (emitted_reg + CW'(1)) == count_reg;

    // store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.insert && !dup_reg && !full) begin
            mem[count_reg[AW-1:0]] <= value_reg;
        end
        rd_data_reg <= mem[idx_reg[AW-1:0]];
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            value_reg <= in_value;
            last_reg  <= in_last;
        end
        if (cmd.scan && pend_reg && eligible && (!have_reg || rd_data_reg < best_reg)) begin
            best_reg <= rd_data_reg;
        end
        if (cmd.push) begin
            prev_reg      <= best_reg;
            out_value_reg <= best_reg;
            out_last_reg  <= final_item;
            out_ovf_reg   <= ovf_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            dup_reg       <= 1'b0;
            have_reg      <= 1'b0;
            first_reg     <= 1'b0;
            emitted_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.load || cmd.sel_init || cmd.push) begin
                idx_reg  <= '0;
                pend_reg <= 1'b0;
                have_reg <= 1'b0;
            end else if (cmd.scan) begin
                pend_reg <= more;
                if (more) begin
                    idx_reg <= idx_reg + CW'(1);
                end
                if (pend_reg && rd_data_reg == value_reg) begin
                    dup_reg <= 1'b1;
                end
                if (pend_reg && eligible) begin
                    have_reg <= 1'b1;
                end
            end
            if (cmd.load) begin
                dup_reg <= 1'b0;
            end
            if (cmd.insert && !dup_reg) begin
                if (full) begin
                    ovf_reg <= 1'b1;
                end else begin
                    count_reg <= count_reg + CW'(1);
                end
            end
            if (cmd.sel_init) begin
                first_reg   <= 1'b1;
                emitted_reg <= '0;
            end
            if (cmd.push) begin
                first_reg   <= 1'b0;
                emitted_reg <= emitted_reg + CW'(1);
            end
            if (cmd.finish) begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            if (cmd.push) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.scan_done  = !more && !pend_reg;
    assign sts.last       = last_reg;
    assign sts.out_free   = !out_valid_reg || out_ready;
    assign sts.final_item = final_item;

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;
    assign out_ovf   = out_ovf_reg;

endmodule

// ----- bench/dedup_merge_insertion_sorter_tb.sv -----
// ----------------------------------------------------------------------------
// dedup_merge_insertion_sorter_tb
// Self-checking bench for the distinct-value sorter.
// ----------------------------------------------------------------------------
// Loads sets of values over the input stream and checks each sorted run against
// a behavioral predictor. The predictor keeps the distinct values of the current
// set and the overflow state, and it queues the ascending run when the set ends.
// A short directed table covers the extremes, duplicates, the ignored padding
// bit and single-value sets. Random sets follow: mostly small ones, plus one
// that fills the store and then sends only duplicates, and one that overflows.
// Both stream sides idle at random.
// ----------------------------------------------------------------------------
module dedup_merge_insertion_sorter_tb;

    localparam int VALUE_W      = dmis_pkg::VALUE_W;
    localparam int TDATA_W      = dmis_pkg::TDATA_W;
    localparam int STORE_DEPTH  = dmis_pkg::DEFAULT_MAX_ITEMS;
    localparam int ITEM_TARGET  = 230;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4 * (STORE_DEPTH + 3);
    localparam int FULL_SET     = 3;
    localparam int OVERFLOW_SET = 8;
    localparam int DIRECTED_N   = 21;
    localparam logic [VALUE_W-1:0] VALUE_MAX = '1;
    localparam logic [TDATA_W-1:0] PAD_BIT   = {1'b1, {VALUE_W{1'b0}}};

    typedef enum int {
        POOL_SMALL,
        POOL_EDGE,
        POOL_WIDE
    } value_mode_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               overflowed;
    } sorted_result_t;

    typedef struct packed {
        logic [TDATA_W-1:0] tdata;
        logic               last;
        logic               typed;
        sorted_result_t     result;
    } directed_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;
    logic               s_tlast;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tlast;
    logic               m_tuser;

    logic [VALUE_W-1:0] held_values[$];
    logic               dropped_distinct;
    sorted_result_t     sorted_expect_q[$];
    sorted_result_t     want;
    int                 mismatches;
    int                 items_sent;
    int                 idle_cycles;
    bit                 no_gaps;

    directed_row_t directed_rows [DIRECTED_N] = '{
        '{32'h0000_0000, 1'b1, 1'b1, '{31'h0000_0000, 1'b1, 1'b0}},
        '{32'h7FFF_FFFF, 1'b1, 1'b1, '{31'h7FFF_FFFF, 1'b1, 1'b0}},
        '{32'h8000_0005, 1'b1, 1'b1, '{31'h0000_0005, 1'b1, 1'b0}},
        '{32'h0000_0009, 1'b0, 1'b0, '0},
        '{32'h0000_0009, 1'b1, 1'b1, '{31'h0000_0009, 1'b1, 1'b0}},
        '{32'h7FFF_FFFF, 1'b0, 1'b0, '0},
        '{32'h0000_0000, 1'b0, 1'b0, '0},
        '{32'h4000_0000, 1'b0, 1'b0, '0},
        '{32'h3FFF_FFFF, 1'b0, 1'b0, '0},
        '{32'h7FFF_FFFE, 1'b0, 1'b0, '0},
        '{32'h0000_0001, 1'b0, 1'b0, '0},
        '{32'h0000_0000, 1'b0, 1'b0, '0},
        '{32'hFFFF_FFFF, 1'b1, 1'b0, '0},
        '{32'h5555_5555, 1'b0, 1'b0, '0},
        '{32'h2AAA_AAAA, 1'b0, 1'b0, '0},
        '{32'hD555_5555, 1'b1, 1'b0, '0},
        '{32'h0000_0012, 1'b0, 1'b0, '0},
        '{32'h0000_0003, 1'b0, 1'b0, '0},
        '{32'h0000_0012, 1'b0, 1'b0, '0},
        '{32'h0000_0003, 1'b1, 1'b0, '0},
        '{32'hAAAA_AAAA, 1'b1, 1'b0, '0}
    };

    dedup_merge_insertion_sorter #(
        .MAX_ITEMS(STORE_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [TDATA_W-1:0] random_tdata(input value_mode_t mode);
        logic [TDATA_W-1:0] word;
        word = $urandom;
        case (mode)
            POOL_SMALL: begin
                word[VALUE_W-1:0] = VALUE_W'($urandom_range(0, 15));
            end
            POOL_EDGE: begin
                case ($urandom_range(0, 3))
                    0: word[VALUE_W-1:0] = '0;
                    1: word[VALUE_W-1:0] = VALUE_MAX;
                    2: word[VALUE_W-1:0] = VALUE_MAX - VALUE_W'($urandom_range(1, 4));
                    default: word[VALUE_W-1:0] = VALUE_W'($urandom_range(1, 4));
                endcase
            end
            default: ;
        endcase
        return word;
    endfunction

    // Updates the set state for one accepted transaction; queues the run on last if keep_results.
    function automatic void absorb_input(input logic [TDATA_W-1:0] tdata, input logic last,
                                         input bit keep_results);
        logic [VALUE_W-1:0] value;
        logic [VALUE_W-1:0] ordered[$];
        bit                 seen;
        int                 pos;
        sorted_result_t     res;
        value = tdata[VALUE_W-1:0];
        seen  = 1'b0;
        foreach (held_values[k])
            if (held_values[k] == value)
                seen = 1'b1;
        if (!seen) begin
            if (held_values.size() < STORE_DEPTH)
                held_values.insert(held_values.size(), value);
            else
                dropped_distinct = 1'b1;
        end
        if (last) begin
            foreach (held_values[k]) begin
                pos = 0;
                while (pos < ordered.size() && ordered[pos] < held_values[k])
                    pos++;
                ordered.insert(pos, held_values[k]);
            end
            if (keep_results) begin
                foreach (ordered[k]) begin
                    res.value      = ordered[k];
                    res.last       = (k == ordered.size() - 1);
                    res.overflowed = dropped_distinct;
                    sorted_expect_q.insert(sorted_expect_q.size(), res);
                end
            end
            held_values.delete();
            dropped_distinct = 1'b0;
        end
    endfunction

    task automatic send_value(input logic [TDATA_W-1:0] tdata, input logic last,
                              input bit keep_results);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= tdata;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        absorb_input(tdata, last, keep_results);
        items_sent++;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_random_set(input int set_idx);
        int                 size;
        int                 tail;
        value_mode_t        mode;
        logic [TDATA_W-1:0] word;
        logic [TDATA_W-1:0] sent[$];
        no_gaps = ($urandom_range(0, 3) == 0);
        if (set_idx == FULL_SET || set_idx == OVERFLOW_SET) begin
            repeat (STORE_DEPTH) begin
                word = random_tdata(POOL_WIDE);
                sent.insert(sent.size(), word);
                send_value(word, 1'b0, 1'b1);
            end
            // store is full now: duplicates must not raise the overflow flag
            tail = $urandom_range(2, 5);
            for (int k = 0; k < tail; k++) begin
                if (set_idx == OVERFLOW_SET && (k == 0 || $urandom_range(0, 1) == 1))
                    word = random_tdata(POOL_WIDE);
                else
                    word = sent[$urandom_range(0, sent.size() - 1)] ^ PAD_BIT;
                send_value(word, k == tail - 1, 1'b1);
            end
        end else begin
            size = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
            mode = value_mode_t'($urandom_range(0, 2));
            for (int k = 0; k < size; k++) begin
                if (sent.size() > 0 && $urandom_range(0, 4) == 0)
                    word = sent[$urandom_range(0, sent.size() - 1)];
                else
                    word = random_tdata(mode);
                sent.insert(sent.size(), word);
                send_value(word, k == size - 1, 1'b1);
            end
        end
    endtask

    initial begin
        int stall;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            m_tready <= 1'b1;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6))
                @(posedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (sorted_expect_q.size() == 0) begin
                    $error("unexpected result transaction: sorted_value %h",
                           m_tdata[VALUE_W-1:0]);
                    mismatches++;
                end else begin
                    want = sorted_expect_q.pop_front();
                    if (m_tdata[VALUE_W-1:0] !== want.value) begin
                        $error("sorted_value: expected %h, got %h", want.value,
                               m_tdata[VALUE_W-1:0]);
                        mismatches++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_out: expected %b, got %b", want.last, m_tlast);
                        mismatches++;
                    end
                    if (m_tuser !== want.overflowed) begin
                        $error("overflowed: expected %b, got %b", want.overflowed, m_tuser);
                        mismatches++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("dedup_merge_insertion_sorter_tb failed");
                $finish;
            end
        end
    end

    initial begin
        int set_idx;
        mismatches       = 0;
        items_sent       = 0;
        idle_cycles      = 0;
        no_gaps          = 1'b0;
        dropped_distinct = 1'b0;
        set_idx          = 0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        aresetn  <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].typed)
                sorted_expect_q.insert(sorted_expect_q.size(), directed_rows[r].result);
            send_value(directed_rows[r].tdata, directed_rows[r].last, !directed_rows[r].typed);
        end

        while (items_sent < ITEM_TARGET) begin
            send_random_set(set_idx);
            set_idx++;
        end
        s_tvalid <= 1'b0;

        while (sorted_expect_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("dedup_merge_insertion_sorter_tb passed");
        else
            $display("dedup_merge_insertion_sorter_tb failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/dmis_pkg.sv
rtl/dmis_ctrl.sv
rtl/dmis_dpath.sv
rtl/dedup_merge_insertion_sorter.sv
bench/dedup_merge_insertion_sorter_tb.sv
